// ===== sv/tnis_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the top-N index selector.
// No dependencies; imported by the interfaces and every module.
package tnis_pkg;

   localparam int LIST_DEPTH_DEF  = 64;
   localparam int VALUE_BITS_DEF  = 32;

   localparam int SAMPLE_BITS     = 32;
   localparam int PICK_INDEX_BITS = 6;
   localparam int PICK_COUNT_BITS = 7;

   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 7;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELECT_MAX = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PICK_COUNT = 1'd1;

   localparam logic [PICK_COUNT_BITS-1:0] PICK_COUNT_RESET = 7'd1;

   // control broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic shift_en;    // load: everything moves one cell towards the head
      logic clear;       // end of run: drop the whole list
      logic mark_en;     // set the used bit of the cell holding mark_idx
      logic select_max;  // 1: larger key wins, 0: smaller key wins
   } chain_ctrl_type;

endpackage

// ===== sv/tnis_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for list elements and picked indexes.
// Depends on tnis_pkg.
interface tnis_req_if import tnis_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic                          is_final;

   modport source (output valid, output sample_value, output is_final, input ready);
   modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface tnis_rsp_if import tnis_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PICK_INDEX_BITS-1:0] picked_index;
   logic                       final_pick;
   logic                       overflow;

   modport source (output valid, output picked_index, output final_pick, output overflow,
                   input ready);
   modport sink   (input valid, input picked_index, input final_pick, input overflow,
                   output ready);
endinterface

// ===== sv/tnis_cell.sv =====
`timescale 1ns / 1ps
// One cell of the selection chain: holds one list entry and one stage of
// the running best-candidate token. Depends on tnis_pkg.
module tnis_cell import tnis_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int IDX_BITS   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chain_ctrl_type        ctrl,
   input  logic [IDX_BITS-1:0]   mark_idx,
   // load path, from the neighbour behind
   input  logic                  ld_valid_in,
   input  logic [VALUE_BITS-1:0] ld_key_in,
   input  logic [IDX_BITS-1:0]   ld_idx_in,
   output logic                  ld_valid_out,
   output logic [VALUE_BITS-1:0] ld_key_out,
   output logic [IDX_BITS-1:0]   ld_idx_out,
   // candidate token, from the neighbour ahead
   input  logic                  tok_have_in,
   input  logic [VALUE_BITS-1:0] tok_key_in,
   input  logic [IDX_BITS-1:0]   tok_idx_in,
   output logic                  tok_have_out,
   output logic [VALUE_BITS-1:0] tok_key_out,
   output logic [IDX_BITS-1:0]   tok_idx_out
);

   logic                  valid_ff, used_ff, tok_have_ff;
   logic [VALUE_BITS-1:0] key_ff, tok_key_ff;
   logic [IDX_BITS-1:0]   idx_ff, tok_idx_ff;
   logic                  eligible, better, take;

   assign eligible = valid_ff & ~used_ff;
   // strict compare: on a tie the earlier (lower index) candidate stays
   assign better   = ctrl.select_max ? (key_ff > tok_key_in) : (key_ff < tok_key_in);
   assign take     = eligible & (~tok_have_in | better);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         used_ff     <= 1'b0;
         tok_have_ff <= 1'b0;
      end else begin
         tok_have_ff <= tok_have_in | eligible;
         if (ctrl.clear) begin
            valid_ff <= 1'b0;
            used_ff  <= 1'b0;
         end else if (ctrl.shift_en) begin
            valid_ff <= ld_valid_in;
            used_ff  <= 1'b0;       // nothing is used while loading
         end else if (ctrl.mark_en && valid_ff && (idx_ff == mark_idx)) begin
            used_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         key_ff <= ld_key_in;
         idx_ff <= ld_idx_in;
      end
      tok_key_ff <= take ? key_ff : tok_key_in;
      tok_idx_ff <= take ? idx_ff : tok_idx_in;
   end

   assign ld_valid_out = valid_ff;
   assign ld_key_out   = key_ff;
   assign ld_idx_out   = idx_ff;
   assign tok_have_out = tok_have_ff;
   assign tok_key_out  = tok_key_ff;
   assign tok_idx_out  = tok_idx_ff;

endmodule

// ===== sv/tnis_chain.sv =====
`timescale 1ns / 1ps
// Row of selection cells. Loads enter at the tail and move to the head;
// the best-candidate token runs head to tail. Depends on tnis_pkg, tnis_cell.
module tnis_chain import tnis_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int IDX_BITS   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chain_ctrl_type        ctrl,
   input  logic [IDX_BITS-1:0]   mark_idx,
   input  logic [VALUE_BITS-1:0] load_key,
   input  logic [IDX_BITS-1:0]   load_idx,
   output logic [IDX_BITS-1:0]   best_idx
);

   logic                  ld_valid [LIST_DEPTH+1];
   logic [VALUE_BITS-1:0] ld_key   [LIST_DEPTH+1];
   logic [IDX_BITS-1:0]   ld_idx   [LIST_DEPTH+1];
   logic                  tok_have [LIST_DEPTH+1];
   logic [VALUE_BITS-1:0] tok_key  [LIST_DEPTH+1];
   logic [IDX_BITS-1:0]   tok_idx  [LIST_DEPTH+1];

   assign ld_valid[LIST_DEPTH] = 1'b1;
   assign ld_key[LIST_DEPTH]   = load_key;
   assign ld_idx[LIST_DEPTH]   = load_idx;

   // a fresh, empty token enters the head every cycle
   assign tok_have[0] = 1'b0;
   assign tok_key[0]  = '0;
   assign tok_idx[0]  = '0;

   for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
      tnis_cell #(
         .VALUE_BITS (VALUE_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .mark_idx     (mark_idx),
         .ld_valid_in  (ld_valid[j+1]),
         .ld_key_in    (ld_key[j+1]),
         .ld_idx_in    (ld_idx[j+1]),
         .ld_valid_out (ld_valid[j]),
         .ld_key_out   (ld_key[j]),
         .ld_idx_out   (ld_idx[j]),
         .tok_have_in  (tok_have[j]),
         .tok_key_in   (tok_key[j]),
         .tok_idx_in   (tok_idx[j]),
         .tok_have_out (tok_have[j+1]),
         .tok_key_out  (tok_key[j+1]),
         .tok_idx_out  (tok_idx[j+1])
      );
   end

   assign best_idx = tok_idx[LIST_DEPTH];

endmodule

// ===== sv/top_n_index_select.sv =====
`timescale 1ns / 1ps
// Top-N index selector. Depends on tnis_pkg, tnis_if, tnis_chain, tnis_cell.
//
// A list of signed Q16.16 values is loaded one transaction per cycle; the
// transaction flagged is_final closes the list. The block then returns the
// list positions of the pick_count smallest values in ascending order (or,
// with select_max set, of the largest in descending order), ties going to
// the lowest position. The count saturates at the number of elements held;
// elements beyond LIST_DEPTH are dropped and every result of that run has
// overflow set. A pick_count of zero gives no results. While a run is being
// returned no new element is taken. Timing: loading runs at one element per
// cycle. Each index costs a scan, the time the candidate token needs to
// travel the row of cells, plus the wait on the result port until the
// consumer takes it. No clearing pass is needed after reset.
module top_n_index_select import tnis_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,  // 2..64
   parameter int VALUE_BITS = VALUE_BITS_DEF   // 8..64
) (
   input  logic                      clock,
   input  logic                      reset,
   tnis_req_if.sink                  req_chan,
   tnis_rsp_if.source                rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS = $clog2(LIST_DEPTH);
   localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);

   // sequencer states
   localparam logic [1:0] ST_LOAD = 2'd0;  // taking list elements
   localparam logic [1:0] ST_SCAN = 2'd1;  // token in flight through the chain
   localparam logic [1:0] ST_EMIT = 2'd2;  // result held on the rsp port

   logic [1:0]                 state_ff, state_in;
   logic [CNT_BITS-1:0]        load_count_ff, load_count_in;
   logic [CNT_BITS-1:0]        scan_cnt_ff, scan_cnt_in;
   logic [PICK_COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic                       overflow_ff, overflow_in;
   logic                       select_max_ff;
   logic [PICK_COUNT_BITS-1:0] pick_count_ff;

   logic [IDX_BITS-1:0]        rsp_idx_ff;
   logic                       rsp_final_ff, rsp_ovf_ff;

   chain_ctrl_type             ctrl;
   logic [IDX_BITS-1:0]        best_idx;
   logic [VALUE_BITS-1:0]      sample_ext;
   logic [VALUE_BITS-1:0]      load_key;
   logic                       req_fire, rsp_fire, full, scan_done;
   logic [CNT_BITS-1:0]        count_after;
   logic [PICK_COUNT_BITS-1:0] count_after_ext, run_len;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         select_max_ff <= 1'b0;
         pick_count_ff <= PICK_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SELECT_MAX: select_max_ff <= csr_wdata[0];
            CSR_PICK_COUNT: pick_count_ff <= csr_wdata[PICK_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---- input side ----
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign full           = (load_count_ff == CNT_BITS'(LIST_DEPTH));

   // sign-extend (or trim) to the store width, then flip the sign bit so
   // that an unsigned compare orders the keys as signed values
   assign sample_ext = VALUE_BITS'(req_chan.sample_value);
   assign load_key   = {~sample_ext[VALUE_BITS-1], sample_ext[VALUE_BITS-2:0]};

   assign count_after     = full ? load_count_ff : load_count_ff + 1'b1;
   assign count_after_ext = PICK_COUNT_BITS'(count_after);
   assign run_len         = (pick_count_ff > count_after_ext) ? count_after_ext
                                                              : pick_count_ff;

   assign rsp_fire  = rsp_chan.valid & rsp_chan.ready;
   assign scan_done = (scan_cnt_ff == CNT_BITS'(LIST_DEPTH));

   // ---- sequencer ----
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      scan_cnt_in   = scan_cnt_ff;
      remaining_in  = remaining_ff;
      overflow_in   = overflow_ff;
      ctrl.shift_en   = 1'b0;
      ctrl.clear      = 1'b0;
      ctrl.mark_en    = 1'b0;
      ctrl.select_max = select_max_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  ctrl.shift_en = 1'b1;
               end
               load_count_in = count_after;
               if (req_chan.is_final) begin
                  if (run_len == '0) begin
                     // nothing to return: drop the list straight away
                     ctrl.clear    = 1'b1;
                     load_count_in = '0;
                     overflow_in   = 1'b0;
                  end else begin
                     remaining_in = run_len;
                     scan_cnt_in  = '0;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               ctrl.mark_en = 1'b1;
               remaining_in = remaining_ff - 1'b1;
               if (rsp_final_ff) begin
                  ctrl.clear    = 1'b1;
                  load_count_in = '0;
                  overflow_in   = 1'b0;
                  state_in      = ST_LOAD;
               end else begin
                  scan_cnt_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         scan_cnt_ff   <= '0;
         remaining_ff  <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         scan_cnt_ff   <= scan_cnt_in;
         remaining_ff  <= remaining_in;
         overflow_ff   <= overflow_in;
      end
   end

   // result register, captured when the token leaves the last cell
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && scan_done) begin
         rsp_idx_ff   <= best_idx;
         rsp_final_ff <= (remaining_ff == PICK_COUNT_BITS'(1));
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_chan.valid        = (state_ff == ST_EMIT);
   assign rsp_chan.picked_index = PICK_INDEX_BITS'(rsp_idx_ff);
   assign rsp_chan.final_pick   = rsp_final_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   // ---- cell row ----
   tnis_chain #(
      .LIST_DEPTH (LIST_DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .mark_idx (rsp_idx_ff),
      .load_key (load_key),
      .load_idx (load_count_ff[IDX_BITS-1:0]),
      .best_idx (best_idx)
   );

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CNT_BITS'(LIST_DEPTH))
      else $error("load count beyond list depth");

   a_no_load_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input open while a result is pending");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (remaining_ff != '0))
      else $error("run active with no picks left");

   a_list_dropped: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.final_pick) |=> (load_count_ff == '0 && !overflow_ff))
      else $error("list not cleared after last result");

endmodule
